// ----- rtl/fcm_pkg.sv -----
// Shared constants and types of the four-channel mixer with meters.
package fcm_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CLIP_DEPTH = 1024;
    localparam int CLIP_AW    = $clog2(CLIP_DEPTH);
    localparam int CLIP_DW    = 15;

    localparam int CFG_IW = $clog2(CHANNELS + 4);
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_MUTE   = CFG_IW'(CHANNELS);
    localparam logic [CFG_IW-1:0] REG_DIRECT = CFG_IW'(CHANNELS + 1);
    localparam logic [CFG_IW-1:0] REG_SOFT   = CFG_IW'(CHANNELS + 2);
    localparam logic [CFG_IW-1:0] REG_DECAY  = CFG_IW'(CHANNELS + 3);

    localparam logic [15:0] LEVEL_RESET = 16'd32768;
    localparam logic [15:0] DECAY_RESET = 16'd175;
    localparam logic [15:0] CV_FULL     = 16'd20480;

    localparam int MUL_AW = 30;
    localparam int MUL_BW = 23;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [MUL_BW-1:0] TANH_STEP    = 23'd6100740;
    localparam logic [MUL_BW-1:0] SOFT_SCALE   = 23'd22528;
    localparam logic [MUL_BW-1:0] RECIP5       = 23'd419431;
    localparam int                RECIP5_SHIFT = 18;

    typedef struct packed {
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic [CLIP_AW-1:0] addr0;
        logic [CLIP_AW-1:0] addr1;
    } t_clip_rd;

    typedef struct packed {
        logic [CLIP_DW-1:0] data0;
        logic [CLIP_DW-1:0] data1;
    } t_clip_data;

endpackage

// ----- rtl/fcm_mul.sv -----
// Shared unsigned multiplier with a registered product.
module fcm_mul (
    input  logic                    i_clk,
    input  fcm_pkg::t_mul_req       i_req,
    output logic [fcm_pkg::MUL_PW-1:0] o_prod
);
    import fcm_pkg::*;

    logic [MUL_PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_PW'(i_req.a) * MUL_PW'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/fcm_clip.sv -----
// Soft clip table: builds the tanh table after reset and serves two reads a cycle.
module fcm_clip (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [fcm_pkg::MUL_PW-1:0] i_prod,
    output fcm_pkg::t_mul_req          o_mul_req,
    output logic                       o_busy,
    input  fcm_pkg::t_clip_rd          i_rd,
    output fcm_pkg::t_clip_data        o_rd
);
    import fcm_pkg::*;

    typedef enum logic [2:0] {B_ENT, B_TA, B_DSET, B_DIV, B_DONE} t_bstate;

    t_bstate            r_state;
    logic               r_busy;
    logic [CLIP_AW-1:0] r_k;
    logic [MUL_AW-1:0]  r_t;
    logic [30:0]        r_d;
    logic [31:0]        r_rem;
    logic [30:0]        r_q;
    logic [30:0]        r_nlo;
    logic [4:0]         r_cnt;

    logic [CLIP_DW-1:0] r_mem [CLIP_DEPTH];
    logic [CLIP_DW-1:0] r_rd0;
    logic [CLIP_DW-1:0] r_rd1;

    logic [45:0]        n_round;
    logic [CLIP_DW-1:0] n_entry;
    logic               n_we;
    logic [30:0]        n_tpa;
    logic [31:0]        n_r2;
    logic               n_qbit;
    logic [31:0]        n_rem;
    logic [30:0]        n_q;

    always_comb begin
        n_round = 46'(i_prod) + 46'(64'd1 << 29);
        n_entry = n_round[30 +: CLIP_DW];
        n_we    = (r_state == B_TA);
        n_tpa   = 31'(r_t) + 31'(TANH_STEP);
        n_r2    = {r_rem[30:0], r_nlo[30]};
        n_qbit  = (n_r2 >= {1'b0, r_d});
        n_rem   = n_qbit ? (n_r2 - {1'b0, r_d}) : n_r2;
        n_q     = {r_q[29:0], n_qbit};
        o_mul_req.a = r_t;
        case (r_state)
            B_ENT:   o_mul_req.b = SOFT_SCALE;
            B_TA:    o_mul_req.b = TANH_STEP;
            default: o_mul_req.b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_ENT;
            r_busy  <= 1'b1;
            r_k     <= '0;
            r_t     <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                B_ENT: begin
                    r_state <= B_TA;
                end
                B_TA: begin
                    if (r_k == CLIP_AW'(CLIP_DEPTH - 1)) begin
                        r_busy  <= 1'b0;
                        r_state <= B_DONE;
                    end else begin
                        r_state <= B_DSET;
                    end
                end
                B_DSET: begin
                    r_d     <= 31'(64'd1 << 30) + 31'(i_prod[MUL_PW-1:30]);
                    r_rem   <= {2'b00, n_tpa[30:1]};
                    r_nlo   <= {n_tpa[0], 30'd0};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_nlo <= {r_nlo[29:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_t     <= n_q[MUL_AW-1:0];
                        r_k     <= r_k + CLIP_AW'(1);
                        r_state <= B_ENT;
                    end
                end
                B_DONE: begin
                    r_state <= B_DONE;
                end
                default: begin
                    r_state <= B_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[r_k] <= n_entry;
        end
        r_rd0 <= r_mem[i_rd.addr0];
        r_rd1 <= r_mem[i_rd.addr1];
    end

    assign o_busy   = r_busy;
    assign o_rd.data0 = r_rd0;
    assign o_rd.data1 = r_rd1;

endmodule

// ----- rtl/four_channel_mixer_with_meters_unit.sv -----
// Four-channel mixer with direct outputs, soft clip and peak meters: top level.
// Items are taken one at a time: each channel passes through the factor, gain, magnitude
// and accumulate steps, and soft clip adds a table read, a multiply and an end step; every
// multiply goes through one shared multiplier. A finished item waits in the output register
// while the next item is accepted. After reset the clip table is built; no item is accepted
// meanwhile, configuration writes are taken.
module four_channel_mixer_with_meters_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fcm_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [fcm_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [15:0]          i_in_ch1,
    input  logic signed [15:0]          i_in_ch2,
    input  logic signed [15:0]          i_in_ch3,
    input  logic signed [15:0]          i_in_ch4,
    input  logic signed [15:0]          i_cv_ch1,
    input  logic signed [15:0]          i_cv_ch2,
    input  logic signed [15:0]          i_cv_ch3,
    input  logic signed [15:0]          i_cv_ch4,
    input  logic [3:0]                  i_cv_patched,
    input  logic                        i_frame_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [15:0]          o_mix_out,
    output logic signed [15:0]          o_mix_inverted,
    output logic signed [15:0]          o_direct_ch1,
    output logic signed [15:0]          o_direct_ch2,
    output logic signed [15:0]          o_direct_ch3,
    output logic signed [15:0]          o_direct_ch4,
    output logic [23:0]                 o_meter_ch1,
    output logic [23:0]                 o_meter_ch2,
    output logic [23:0]                 o_meter_ch3,
    output logic [23:0]                 o_meter_ch4
);
    import fcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FAC, S_GAIN, S_MAG, S_ACC, S_CLIP_RD, S_CLIP_MUL, S_CLIP_END, S_DONE
    } t_state;

    localparam logic signed [18:0] RAIL_P = 19'sd24576;
    localparam logic signed [18:0] RAIL_N = -19'sd24576;

    function automatic logic signed [15:0] clamp_rail(input logic signed [18:0] v);
        if (v > RAIL_P) begin
            return 16'(RAIL_P);
        end else if (v < RAIL_N) begin
            return 16'(RAIL_N);
        end else begin
            return 16'(v);
        end
    endfunction

    // Configuration registers
    logic [15:0]         r_level [CHANNELS];
    logic [CHANNELS-1:0] r_mute;
    logic [CHANNELS-1:0] r_direct_mask;
    logic                r_soft;
    logic [15:0]         r_decay;

    // Sequencer state
    t_state              r_state;
    logic [CH_W-1:0]     r_ch;
    logic signed [15:0]  r_x [CHANNELS];
    logic signed [15:0]  r_cv [CHANNELS];
    logic [CHANNELS-1:0] r_patched;
    logic                r_last;
    logic signed [18:0]  r_sum;
    logic signed [15:0]  r_direct [CHANNELS];
    logic [23:0]         r_meter [CHANNELS];
    logic [6:0]          r_frac;
    logic                r_over;
    logic                r_mix_neg;
    logic [CLIP_DW-1:0]  r_d0;

    // Output register
    logic                r_out_valid;
    logic signed [15:0]  r_o_mix;
    logic signed [15:0]  r_o_inv;
    logic signed [15:0]  r_o_direct [CHANNELS];
    logic [23:0]         r_o_meter [CHANNELS];

    t_mul_req            n_seq_req;
    t_mul_req            n_clip_req;
    t_mul_req            n_mul_req;
    logic [MUL_PW-1:0]   n_prod;
    logic                n_busy;
    t_clip_rd            n_rd;
    t_clip_data          n_rd_data;

    logic signed [15:0]  n_x;
    logic signed [15:0]  n_cv;
    logic [15:0]         n_knob;
    logic                n_neg;
    logic [15:0]         n_ax;
    logic                n_cv_le0;
    logic                n_cv_full;
    logic [15:0]         n_fac;
    logic [15:0]         n_gain_pat;
    logic [15:0]         n_gain;
    logic [15:0]         n_mag;
    logic signed [17:0]  n_v;
    logic [23:0]         n_cand;
    logic [18:0]         n_s;
    logic [11:0]         n_idx;
    logic                n_over;
    logic [CLIP_DW-1:0]  n_diff;
    logic [CLIP_DW-1:0]  n_m;
    logic signed [15:0]  n_mix;
    logic [23:0]         n_dec [CHANNELS];
    logic                n_accept;
    logic                n_load;

    fcm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (n_mul_req),
        .o_prod (n_prod)
    );

    fcm_clip u_clip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_prod    (n_prod),
        .o_mul_req (n_clip_req),
        .o_busy    (n_busy),
        .i_rd      (n_rd),
        .o_rd      (n_rd_data)
    );

    assign o_in_stall = n_busy || (r_state != S_IDLE);
    assign n_accept   = i_in_valid && !o_in_stall;
    assign n_load     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign n_mul_req  = n_busy ? n_clip_req : n_seq_req;

    always_comb begin
        n_x        = r_x[r_ch];
        n_cv       = r_cv[r_ch];
        n_knob     = r_level[r_ch];
        n_neg      = n_x[15];
        n_ax       = n_neg ? (~n_x + 16'd1) : n_x;
        n_cv_le0   = n_cv[15] || (n_cv == 16'sd0);
        n_cv_full  = !n_cv[15] && (n_cv >= CV_FULL);
        n_fac      = n_prod[RECIP5_SHIFT +: 16];
        n_gain_pat = n_cv_le0 ? 16'd0 : (n_cv_full ? n_knob : n_prod[30:15]);
        n_gain     = r_mute[r_ch] ? 16'd0 : (r_patched[r_ch] ? n_gain_pat : n_knob);
        n_mag      = n_prod[30:15];
        n_v        = n_neg ? -$signed({2'b00, n_mag}) : $signed({2'b00, n_mag});
        n_cand     = {n_mag, 8'd0};
        n_s        = r_sum[18] ? 19'(-r_sum) : r_sum;
        n_idx      = n_s[18:7];
        n_over     = (n_idx >= 12'(CLIP_DEPTH - 1));
        n_rd.addr0 = n_over ? CLIP_AW'(CLIP_DEPTH - 1) : n_idx[CLIP_AW-1:0];
        n_rd.addr1 = n_rd.addr0 + CLIP_AW'(1);
        n_diff     = n_rd_data.data1 - n_rd_data.data0;
        n_m        = r_d0 + n_prod[7 +: CLIP_DW];
        n_mix      = clamp_rail(r_sum);
        for (int i = 0; i < CHANNELS; i++) begin
            n_dec[i] = (r_meter[i] > 24'(r_decay)) ? (r_meter[i] - 24'(r_decay)) : 24'd0;
        end
        n_seq_req.a = '0;
        n_seq_req.b = '0;
        case (r_state)
            S_FAC: begin
                n_seq_req.a = MUL_AW'(n_cv[14:0]);
                n_seq_req.b = RECIP5;
            end
            S_GAIN: begin
                n_seq_req.a = MUL_AW'(n_knob);
                n_seq_req.b = MUL_BW'(n_fac);
            end
            S_MAG: begin
                n_seq_req.a = MUL_AW'(n_ax);
                n_seq_req.b = MUL_BW'(n_gain);
            end
            S_CLIP_MUL: begin
                n_seq_req.a = MUL_AW'(n_diff);
                n_seq_req.b = r_over ? '0 : MUL_BW'(r_frac);
            end
            default: begin
                n_seq_req.a = '0;
                n_seq_req.b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_level[i] <= LEVEL_RESET;
            end
            r_mute        <= '0;
            r_direct_mask <= '0;
            r_soft        <= 1'b0;
            r_decay       <= DECAY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index < CFG_IW'(CHANNELS)) begin
                r_level[i_cfg_index[CH_W-1:0]] <= i_cfg_data;
            end else begin
                case (i_cfg_index)
                    REG_MUTE:   r_mute        <= i_cfg_data[CHANNELS-1:0];
                    REG_DIRECT: r_direct_mask <= i_cfg_data[CHANNELS-1:0];
                    REG_SOFT:   r_soft        <= i_cfg_data[0];
                    REG_DECAY:  r_decay       <= i_cfg_data;
                    default:    r_soft        <= r_soft;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_meter[i] <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && !n_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_x[0]    <= i_in_ch1;
                        r_x[1]    <= i_in_ch2;
                        r_x[2]    <= i_in_ch3;
                        r_x[3]    <= i_in_ch4;
                        r_cv[0]   <= i_cv_ch1;
                        r_cv[1]   <= i_cv_ch2;
                        r_cv[2]   <= i_cv_ch3;
                        r_cv[3]   <= i_cv_ch4;
                        r_patched <= i_cv_patched;
                        r_last    <= i_frame_last;
                        r_sum     <= '0;
                        r_ch      <= '0;
                        r_state   <= S_FAC;
                    end
                end
                S_FAC: begin
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_direct_mask[r_ch]) begin
                        r_direct[r_ch] <= clamp_rail(19'(n_v));
                    end else begin
                        r_direct[r_ch] <= '0;
                        r_sum          <= r_sum + 19'(n_v);
                    end
                    if (n_cand > r_meter[r_ch]) begin
                        r_meter[r_ch] <= n_cand;
                    end
                    if (r_ch == CH_W'(CHANNELS - 1)) begin
                        r_state <= r_soft ? S_CLIP_RD : S_DONE;
                    end else begin
                        r_ch    <= r_ch + CH_W'(1);
                        r_state <= S_FAC;
                    end
                end
                S_CLIP_RD: begin
                    r_frac    <= n_s[6:0];
                    r_over    <= n_over;
                    r_mix_neg <= r_sum[18];
                    r_state   <= S_CLIP_MUL;
                end
                S_CLIP_MUL: begin
                    r_d0    <= n_rd_data.data0;
                    r_state <= S_CLIP_END;
                end
                S_CLIP_END: begin
                    r_sum   <= r_mix_neg ? -$signed(19'(n_m)) : $signed(19'(n_m));
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_load) begin
                        r_out_valid <= 1'b1;
                        r_o_mix     <= n_mix;
                        r_o_inv     <= -n_mix;
                        for (int i = 0; i < CHANNELS; i++) begin
                            r_o_direct[i] <= r_direct[i];
                            r_o_meter[i]  <= r_last ? n_dec[i] : r_meter[i];
                            if (r_last) begin
                                r_meter[i] <= n_dec[i];
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mix_out      = r_o_mix;
    assign o_mix_inverted = r_o_inv;
    assign o_direct_ch1   = r_o_direct[0];
    assign o_direct_ch2   = r_o_direct[1];
    assign o_direct_ch3   = r_o_direct[2];
    assign o_direct_ch4   = r_o_direct[3];
    assign o_meter_ch1    = r_o_meter[0];
    assign o_meter_ch2    = r_o_meter[1];
    assign o_meter_ch3    = r_o_meter[2];
    assign o_meter_ch4    = r_o_meter[3];

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the four-channel mixer with direct outputs, soft clip and meters.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcm_pkg::*;

    localparam int                UNITY_GAIN     = 32768;
    localparam int                CV_TOP         = 20480;
    localparam int                RAIL_LIMIT     = 24576;
    localparam longint unsigned   TANH_INC       = 64'd6100740;
    localparam longint unsigned   SOFT_GAIN      = 64'd22528;
    localparam int                WATCHDOG_LIMIT = 200000;
    localparam int                RANDOM_PHASES  = 10;
    localparam int                PHASE_ITEMS    = 173;

    localparam logic [CFG_IW-1:0] REG_LEVEL_CH1  = '0;

    typedef struct packed {
        logic [CHANNELS-1:0][15:0] volt;
        logic [CHANNELS-1:0][15:0] cv;
        logic [CHANNELS-1:0]       patched;
        logic                      last;
    } t_frame;

    typedef struct packed {
        logic [15:0]               mix;
        logic [15:0]               mix_inv;
        logic [CHANNELS-1:0][15:0] direct;
        logic [CHANNELS-1:0][23:0] meter;
    } t_mix_result;

    typedef struct packed {
        logic [CHANNELS-1:0][15:0] level;
        logic [15:0]               mute;
        logic [15:0]               direct;
        logic [15:0]               clip_on;
        logic [15:0]               decay;
    } t_mixer_cfg;

    class mixer_scoreboard;
        int unsigned   clip_tab[CLIP_DEPTH];
        int unsigned   level[CHANNELS];
        logic [CHANNELS-1:0] mute;
        logic [CHANNELS-1:0] direct;
        logic          clip_on;
        int unsigned   decay;
        int unsigned   meter[CHANNELS];
        t_mix_result   expected_q[$];
        int            errors;
        int            frames;
        int            results;

        function new();
            longint unsigned t;
            int k;
            t = 0;
            for (k = 0; k < CLIP_DEPTH; k++) begin
                clip_tab[k] = int'((t * SOFT_GAIN + (64'd1 << 29)) >> 30);
                t = ((t + TANH_INC) << 30) / ((64'd1 << 30) + ((t * TANH_INC) >> 30));
            end
            for (k = 0; k < CHANNELS; k++) begin
                level[k] = UNITY_GAIN;
                meter[k] = 0;
            end
            mute = '0;
            direct = '0;
            clip_on = 1'b0;
            decay = 175;
            errors = 0;
            frames = 0;
            results = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            if (idx < REG_MUTE) begin
                level[idx[CH_W-1:0]] = data[15:0];
            end else begin
                case (idx)
                    REG_MUTE:   mute = data[CHANNELS-1:0];
                    REG_DIRECT: direct = data[CHANNELS-1:0];
                    REG_SOFT:   clip_on = data[0];
                    REG_DECAY:  decay = data[15:0];
                    default: ;
                endcase
            end
        endfunction

        function int clamp_rail(int v);
            if (v > RAIL_LIMIT) return RAIL_LIMIT;
            if (v < -RAIL_LIMIT) return -RAIL_LIMIT;
            return v;
        endfunction

        function int unsigned soft_mag(int unsigned s);
            int unsigned i;
            int unsigned f;
            i = s >> 7;
            f = s & 127;
            if (i + 1 >= CLIP_DEPTH) return clip_tab[CLIP_DEPTH-1];
            return clip_tab[i] + (((clip_tab[i+1] - clip_tab[i]) * f) >> 7);
        endfunction

        function void note_frame(t_frame f);
            t_mix_result r;
            int x, cv, v, sum, mix;
            int unsigned gain, fac, ax, mag, cand, s, m;
            int ch;
            r = '0;
            sum = 0;
            for (ch = 0; ch < CHANNELS; ch++) begin
                x = $signed(f.volt[ch]);
                cv = $signed(f.cv[ch]);
                gain = level[ch];
                if (f.patched[ch]) begin
                    if (cv <= 0) fac = 0;
                    else if (cv >= CV_TOP) fac = UNITY_GAIN;
                    else fac = (cv * 8) / 5;
                    gain = (gain * fac) >> 15;
                end
                if (mute[ch]) gain = 0;
                ax = (x < 0) ? -x : x;
                mag = (ax * gain) >> 15;
                v = (x < 0) ? -int'(mag) : int'(mag);
                if (direct[ch]) r.direct[ch] = 16'(clamp_rail(v));
                else sum += v;
                cand = (mag << 8) & 32'h00FF_FFFF;
                if (cand > meter[ch]) meter[ch] = cand;
            end
            mix = sum;
            if (clip_on) begin
                s = (mix < 0) ? -mix : mix;
                m = soft_mag(s);
                mix = (mix < 0) ? -int'(m) : int'(m);
            end
            mix = clamp_rail(mix);
            r.mix = 16'(mix);
            r.mix_inv = 16'(-mix);
            for (ch = 0; ch < CHANNELS; ch++) begin
                if (f.last) meter[ch] = (meter[ch] > decay) ? meter[ch] - decay : 0;
                r.meter[ch] = 24'(meter[ch]);
            end
            expected_q.push_back(r);
            frames++;
        endfunction

        function void compare_field(string name, logic [23:0] exp_v, logic [23:0] got_v);
            if (got_v !== exp_v) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch on %s of result %0d: expected %h, got %h",
                             name, results, exp_v, got_v);
            end
        endfunction

        function void check_result(t_mix_result got);
            t_mix_result exp_r;
            int ch;
            results++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result %0d with no frame waiting", results);
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("mix_out", exp_r.mix, got.mix);
            compare_field("mix_inverted", exp_r.mix_inv, got.mix_inv);
            for (ch = 0; ch < CHANNELS; ch++) begin
                compare_field($sformatf("direct_ch%0d", ch + 1), exp_r.direct[ch],
                              got.direct[ch]);
                compare_field($sformatf("meter_ch%0d", ch + 1), exp_r.meter[ch],
                              got.meter[ch]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flush();
            if (expected_q.size() != 0) begin
                errors += expected_q.size();
                $display("%0d expected results never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]   i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic signed [15:0]  i_in_ch1 = '0, i_in_ch2 = '0, i_in_ch3 = '0, i_in_ch4 = '0;
    logic signed [15:0]  i_cv_ch1 = '0, i_cv_ch2 = '0, i_cv_ch3 = '0, i_cv_ch4 = '0;
    logic [3:0]          i_cv_patched = '0;
    logic                i_frame_last = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic signed [15:0]  o_mix_out, o_mix_inverted;
    logic signed [15:0]  o_direct_ch1, o_direct_ch2, o_direct_ch3, o_direct_ch4;
    logic [23:0]         o_meter_ch1, o_meter_ch2, o_meter_ch3, o_meter_ch4;

    mixer_scoreboard     sb;
    t_mix_result         seen;
    int                  in_gap_pct = 0;
    int                  stall_pct = 0;
    int                  stall_left = 0;
    int                  idle_cycles = 0;
    int                  n_settings = 0;

    four_channel_mixer_with_meters_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_ch1       (i_in_ch1),
        .i_in_ch2       (i_in_ch2),
        .i_in_ch3       (i_in_ch3),
        .i_in_ch4       (i_in_ch4),
        .i_cv_ch1       (i_cv_ch1),
        .i_cv_ch2       (i_cv_ch2),
        .i_cv_ch3       (i_cv_ch3),
        .i_cv_ch4       (i_cv_ch4),
        .i_cv_patched   (i_cv_patched),
        .i_frame_last   (i_frame_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mix_out      (o_mix_out),
        .o_mix_inverted (o_mix_inverted),
        .o_direct_ch1   (o_direct_ch1),
        .o_direct_ch2   (o_direct_ch2),
        .o_direct_ch3   (o_direct_ch3),
        .o_direct_ch4   (o_direct_ch4),
        .o_meter_ch1    (o_meter_ch1),
        .o_meter_ch2    (o_meter_ch2),
        .o_meter_ch3    (o_meter_ch3),
        .o_meter_ch4    (o_meter_ch4)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.mix = o_mix_out;
            seen.mix_inv = o_mix_inverted;
            seen.direct = {o_direct_ch4, o_direct_ch3, o_direct_ch2, o_direct_ch1};
            seen.meter = {o_meter_ch4, o_meter_ch3, o_meter_ch2, o_meter_ch1};
            sb.check_result(seen);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic load_config(t_mixer_cfg c);
        logic [CFG_IW-1:0] idx;
        logic [CFG_DW-1:0] data;
        int r;
        for (r = 0; r < CHANNELS + 4; r++) begin
            idx = REG_LEVEL_CH1 + CFG_IW'(r);
            data = '0;
            if (idx < REG_MUTE) begin
                data = c.level[r];
            end else begin
                case (idx)
                    REG_MUTE:   data = c.mute;
                    REG_DIRECT: data = c.direct;
                    REG_SOFT:   data = c.clip_on;
                    REG_DECAY:  data = c.decay;
                    default: ;
                endcase
            end
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
            sb.write_reg(idx, data);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_frame(t_frame f, bit hold);
        int n;
        if (hold) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            wait_drain();
        end else if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            n = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_ch1 <= f.volt[0];
        i_in_ch2 <= f.volt[1];
        i_in_ch3 <= f.volt[2];
        i_in_ch4 <= f.volt[3];
        i_cv_ch1 <= f.cv[0];
        i_cv_ch2 <= f.cv[1];
        i_cv_ch3 <= f.cv[2];
        i_cv_ch4 <= f.cv[3];
        i_cv_patched <= f.patched;
        i_frame_last <= f.last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_frame(f);
    endtask

    task automatic end_phase();
        i_in_valid <= 1'b0;
        wait_drain();
    endtask

    function automatic t_frame even_frame(int volt, int cv, logic [CHANNELS-1:0] patched,
                                          logic last);
        t_frame f;
        int ch;
        for (ch = 0; ch < CHANNELS; ch++) begin
            f.volt[ch] = 16'(volt);
            f.cv[ch] = 16'(cv);
        end
        f.patched = patched;
        f.last = last;
        return f;
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        int ch, k, x;
        for (ch = 0; ch < CHANNELS; ch++) begin
            case ($urandom_range(0, 5))
                0: x = int'($urandom_range(0, 65535)) - 32768;
                1: begin
                    case ($urandom_range(0, 4))
                        0: x = 32767;
                        1: x = -32768;
                        2: x = 0;
                        3: x = 1;
                        default: x = -1;
                    endcase
                end
                default: begin
                    k = $urandom_range(1, 15);
                    x = int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k);
                end
            endcase
            f.volt[ch] = 16'(x);
            case ($urandom_range(0, 3))
                0: x = int'($urandom_range(0, 65535)) - 32768;
                1: begin
                    case ($urandom_range(0, 7))
                        0: x = 0;
                        1: x = 1;
                        2: x = -1;
                        3: x = 20479;
                        4: x = 20480;
                        5: x = 20481;
                        6: x = 32767;
                        default: x = -32768;
                    endcase
                end
                default: x = $urandom_range(0, CV_TOP);
            endcase
            f.cv[ch] = 16'(x);
        end
        f.patched = CHANNELS'($urandom);
        f.last = ($urandom_range(0, 3) == 0);
        return f;
    endfunction

    function automatic logic [15:0] mask_value();
        if ($urandom_range(0, 1) != 0) return 16'($urandom);
        return 16'($urandom) & 16'hFFF0;
    endfunction

    function automatic t_mixer_cfg random_config(int p);
        t_mixer_cfg c;
        int ch, sel;
        for (ch = 0; ch < CHANNELS; ch++) begin
            sel = (p < 3) ? (p + ch) % 3 : $urandom_range(0, 4);
            case (sel)
                0: c.level[ch] = 16'd32768;
                1: c.level[ch] = 16'hFFFF;
                2: c.level[ch] = 16'd0;
                3: c.level[ch] = 16'($urandom_range(0, UNITY_GAIN));
                default: c.level[ch] = 16'($urandom);
            endcase
        end
        c.mute = (p == 0) ? 16'h0000 : mask_value();
        c.direct = (p == 1) ? 16'hFFFF : mask_value();
        c.clip_on = (p % 2 != 0) ? (16'($urandom) | 16'h0001) : (16'($urandom) & 16'hFFFE);
        case (p % 4)
            0: c.decay = 16'd0;
            1: c.decay = 16'hFFFF;
            2: c.decay = 16'd175;
            default: c.decay = 16'($urandom);
        endcase
        return c;
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    initial begin
        t_mixer_cfg cfg;
        t_frame f;
        int p, i;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_gap_pct = 20;
        stall_pct = 15;

        cfg.level = {CHANNELS{16'd32768}};
        cfg.mute = 16'h0000;
        cfg.direct = 16'h0000;
        cfg.clip_on = 16'h0000;
        cfg.decay = 16'd175;
        load_config(cfg);
        send_frame(even_frame(0, 0, '0, 1'b0), 1'b0);
        send_frame(even_frame(32767, 0, '0, 1'b0), 1'b0);
        send_frame(even_frame(-32768, 0, '0, 1'b1), 1'b0);
        send_frame(even_frame(20000, 0, '1, 1'b0), 1'b0);
        send_frame(even_frame(20000, -32768, '1, 1'b0), 1'b0);
        send_frame(even_frame(20000, 1, '1, 1'b0), 1'b0);
        send_frame(even_frame(20000, 20479, '1, 1'b0), 1'b0);
        send_frame(even_frame(20000, 20480, '1, 1'b1), 1'b0);
        send_frame(even_frame(-20000, 32767, '1, 1'b0), 1'b0);
        f.volt = {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
        f.cv = {16'h0000, 16'd10240, 16'd20481, 16'hFFFF};
        f.patched = 4'b0110;
        f.last = 1'b1;
        send_frame(f, 1'b0);
        end_phase();

        // Gain above unity, one muted channel, two direct channels and the largest decay.
        cfg.level = {16'd12345, 16'd32768, 16'd0, 16'hFFFF};
        cfg.mute = 16'hFFF2;
        cfg.direct = 16'h0005;
        cfg.clip_on = 16'hFFFF;
        cfg.decay = 16'hFFFF;
        load_config(cfg);
        send_frame(even_frame(32767, 0, '0, 1'b0), 1'b0);
        send_frame(even_frame(-32768, 20480, 4'b1010, 1'b1), 1'b0);
        send_frame(even_frame(0, 0, '0, 1'b1), 1'b0);
        send_frame(even_frame(12000, 15000, '1, 1'b0), 1'b0);
        end_phase();

        // Soft clip across the table and past its last entry.
        cfg.level = {CHANNELS{16'hFFFF}};
        cfg.mute = 16'hFFF0;
        cfg.direct = 16'h0000;
        cfg.clip_on = 16'h0001;
        cfg.decay = 16'h0000;
        load_config(cfg);
        send_frame(even_frame(32767, 0, '0, 1'b0), 1'b0);
        send_frame(even_frame(-32768, 0, '0, 1'b1), 1'b0);
        send_frame(even_frame(250, 0, '0, 1'b0), 1'b0);
        send_frame(even_frame(-5000, 0, '0, 1'b0), 1'b0);
        send_frame(even_frame(16383, 0, '0, 1'b0), 1'b0);
        send_frame(even_frame(16320, 0, '0, 1'b1), 1'b0);
        end_phase();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1) begin
                in_gap_pct = 0;
                stall_pct = 0;
            end else begin
                in_gap_pct = pick_rate();
                stall_pct = pick_rate();
            end
            load_config(random_config(p));
            for (i = 0; i < PHASE_ITEMS; i++)
                send_frame(random_frame(), (p == 4 && i == PHASE_ITEMS / 2));
            end_phase();
        end

        repeat (40) @(posedge i_clk);
        sb.flush();
        $display("Summary: %0d frames sent, %0d results checked over %0d register settings.",
                 sb.frames, sb.results, n_settings);
        $display("Covered gains 0 to 2, mute, direct routing, soft clip on and off, "
                 , "meter decay 0 to 65535, with and without stalls.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
